FILE: rtl/jse_pkg.sv
// Shared types, output slot codes and character helpers for the JSON string escaper.
package jse_pkg;

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = $clog2(FIFO_DEPTH);
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int NUM_SLOTS = 16;

	localparam logic [3:0] SLOT_OPEN = 4'd0;
	localparam logic [3:0] SLOT_C1_BSL = 4'd1;
	localparam logic [3:0] SLOT_C1_U = 4'd2;
	localparam logic [3:0] SLOT_C1_D3 = 4'd3;
	localparam logic [3:0] SLOT_C1_D2 = 4'd4;
	localparam logic [3:0] SLOT_C1_D1 = 4'd5;
	localparam logic [3:0] SLOT_C1_D0 = 4'd6;
	localparam logic [3:0] SLOT_ESC_BSL = 4'd7;
	localparam logic [3:0] SLOT_CHR = 4'd8;
	localparam logic [3:0] SLOT_C2_BSL = 4'd9;
	localparam logic [3:0] SLOT_C2_U = 4'd10;
	localparam logic [3:0] SLOT_C2_D3 = 4'd11;
	localparam logic [3:0] SLOT_C2_D2 = 4'd12;
	localparam logic [3:0] SLOT_C2_D1 = 4'd13;
	localparam logic [3:0] SLOT_C2_D0 = 4'd14;
	localparam logic [3:0] SLOT_CLOSE = 4'd15;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL = 8'h5c;
	localparam logic [7:0] CH_U = 8'h75;

	typedef struct packed {
		logic [15:0] mask;
		logic [15:0] code1;
		logic [15:0] code2;
		logic [7:0]  chr;
	} cmd_t;

	function automatic logic [7:0] hex_digit(input logic [3:0] v);
		logic [7:0] r;
		if (v < 4'd10) begin
			r = 8'h30 + {4'h0, v};
		end else begin
			r = 8'h61 + {4'h0, v} - 8'd10;
		end
		return r;
	endfunction

	function automatic logic [7:0] escape_letter(input logic [7:0] b);
		logic [7:0] r;
		unique case (b)
			8'h08: r = 8'h62;
			8'h09: r = 8'h74;
			8'h0a: r = 8'h6e;
			8'h0c: r = 8'h66;
			8'h0d: r = 8'h72;
			8'h22: r = 8'h22;
			8'h2f: r = 8'h2f;
			8'h5c: r = 8'h5c;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/jse_front.sv
// Front end: accepts bytes, tracks UTF-8 decode state and classifies each byte into a command.
module jse_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             accept,
	input  logic [7:0]       data_byte,
	input  logic             is_first,
	input  logic             is_last,
	output logic             cmd_push,
	output jse_pkg::cmd_t    cmd
);

	logic [2:0]  rem_q;
	logic [30:0] acc_q;
	logic [2:0]  rem_e;
	logic [30:0] acc_e;
	logic [2:0]  rem_w;
	logic [30:0] acc_w;
	logic [30:0] acc_sh;
	logic [30:0] c1_val;
	logic        c1_on;
	logic        handled;
	logic [7:0]  letter;

	always_comb begin
		rem_e = is_first ? 3'd0 : rem_q;
		acc_e = is_first ? 31'd0 : acc_q;
		acc_sh = {acc_e[24:0], data_byte[5:0]};
		rem_w = rem_e;
		acc_w = acc_e;
		c1_val = 31'd0;
		c1_on = 1'b0;
		handled = 1'b0;
		letter = jse_pkg::escape_letter(data_byte);
		cmd = '0;

		if (is_first) begin
			cmd.mask[jse_pkg::SLOT_OPEN] = 1'b1;
		end

		if (rem_e != 3'd0) begin
			if (data_byte[7:6] == 2'b10) begin
				handled = 1'b1;
				rem_w = rem_e - 3'd1;
				if (rem_w == 3'd0) begin
					c1_val = acc_sh;
					c1_on = 1'b1;
					acc_w = 31'd0;
				end else begin
					acc_w = acc_sh;
				end
			end else begin
				c1_val = acc_e;
				c1_on = 1'b1;
				rem_w = 3'd0;
				acc_w = 31'd0;
			end
		end

		if (c1_on && c1_val != 31'd0 && c1_val[30:16] == 15'd0) begin
			cmd.mask[jse_pkg::SLOT_C1_D0:jse_pkg::SLOT_C1_BSL] = '1;
			cmd.code1 = c1_val[15:0];
		end

		if (!handled) begin
			priority if (data_byte[7] == 1'b0) begin
				if (data_byte != 8'h00) begin
					cmd.mask[jse_pkg::SLOT_CHR] = 1'b1;
					if (letter != 8'h00) begin
						cmd.mask[jse_pkg::SLOT_ESC_BSL] = 1'b1;
						cmd.chr = letter;
					end else begin
						cmd.chr = data_byte;
					end
				end
			end else if (data_byte[6] == 1'b0) begin
				cmd.mask[jse_pkg::SLOT_CHR] = 1'b1;
				cmd.chr = data_byte;
			end else if (data_byte[5] == 1'b0) begin
				rem_w = 3'd1;
				acc_w = {26'd0, data_byte[4:0]};
			end else if (data_byte[4] == 1'b0) begin
				rem_w = 3'd2;
				acc_w = {27'd0, data_byte[3:0]};
			end else if (data_byte[3] == 1'b0) begin
				rem_w = 3'd3;
				acc_w = {28'd0, data_byte[2:0]};
			end else if (data_byte[2] == 1'b0) begin
				rem_w = 3'd4;
				acc_w = {29'd0, data_byte[1:0]};
			end else if (data_byte[1] == 1'b0) begin
				rem_w = 3'd5;
				acc_w = {30'd0, data_byte[0]};
			end else begin
				cmd.mask[jse_pkg::SLOT_CHR] = 1'b1;
				cmd.chr = data_byte;
			end
		end

		if (is_last) begin
			if (rem_w != 3'd0 && acc_w != 31'd0 && acc_w[30:16] == 15'd0) begin
				cmd.mask[jse_pkg::SLOT_C2_D0:jse_pkg::SLOT_C2_BSL] = '1;
				cmd.code2 = acc_w[15:0];
			end
			rem_w = 3'd0;
			acc_w = 31'd0;
			cmd.mask[jse_pkg::SLOT_CLOSE] = 1'b1;
		end
	end

	assign cmd_push = accept && (cmd.mask != 16'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 3'd0;
			acc_q <= 31'd0;
		end else if (accept) begin
			rem_q <= rem_w;
			acc_q <= acc_w;
		end
	end

endmodule

FILE: rtl/jse_fifo.sv
// Short command queue between the front end and the output sequencer.
module jse_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jse_pkg::cmd_t wdata,
	output logic          full,
	input  logic          pop,
	output jse_pkg::cmd_t rdata,
	output logic          empty
);

	jse_pkg::cmd_t                  mem_q [jse_pkg::FIFO_DEPTH];
	logic [jse_pkg::PTR_W-1:0]      wr_q;
	logic [jse_pkg::PTR_W-1:0]      rd_q;
	logic [jse_pkg::CNT_W-1:0]      cnt_q;
	logic                           do_push;
	logic                           do_pop;

	assign full = (cnt_q == jse_pkg::CNT_W'(jse_pkg::FIFO_DEPTH));
	assign empty = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop = pop && !empty;
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/jse_back.sv
// Back end: expands commands into the output register, one byte per cycle unless stalled.
module jse_back (
	input  logic          clk,
	input  logic          arst_n,
	input  jse_pkg::cmd_t head,
	input  logic          head_empty,
	output logic          head_pop,
	output logic [7:0]    out_byte,
	output logic          out_last,
	output logic          empty,
	input  logic          pop
);

	jse_pkg::cmd_t cur_q;
	logic [15:0]   rem_q;
	logic [15:0]   rem_after;
	logic [3:0]    slot;
	logic [7:0]    slot_byte;
	logic          out_v_q;
	logic [7:0]    out_byte_q;
	logic          out_last_q;
	logic          load_ok;
	logic          adv;

	always_comb begin
		slot = 4'd0;
		for (int i = jse_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (rem_q[i]) begin
				slot = 4'(i);
			end
		end
	end

	always_comb begin
		unique case (slot)
			jse_pkg::SLOT_OPEN:    slot_byte = jse_pkg::CH_QUOTE;
			jse_pkg::SLOT_C1_BSL:  slot_byte = jse_pkg::CH_BSL;
			jse_pkg::SLOT_C1_U:    slot_byte = jse_pkg::CH_U;
			jse_pkg::SLOT_C1_D3:   slot_byte = jse_pkg::hex_digit(cur_q.code1[15:12]);
			jse_pkg::SLOT_C1_D2:   slot_byte = jse_pkg::hex_digit(cur_q.code1[11:8]);
			jse_pkg::SLOT_C1_D1:   slot_byte = jse_pkg::hex_digit(cur_q.code1[7:4]);
			jse_pkg::SLOT_C1_D0:   slot_byte = jse_pkg::hex_digit(cur_q.code1[3:0]);
			jse_pkg::SLOT_ESC_BSL: slot_byte = jse_pkg::CH_BSL;
			jse_pkg::SLOT_CHR:     slot_byte = cur_q.chr;
			jse_pkg::SLOT_C2_BSL:  slot_byte = jse_pkg::CH_BSL;
			jse_pkg::SLOT_C2_U:    slot_byte = jse_pkg::CH_U;
			jse_pkg::SLOT_C2_D3:   slot_byte = jse_pkg::hex_digit(cur_q.code2[15:12]);
			jse_pkg::SLOT_C2_D2:   slot_byte = jse_pkg::hex_digit(cur_q.code2[11:8]);
			jse_pkg::SLOT_C2_D1:   slot_byte = jse_pkg::hex_digit(cur_q.code2[7:4]);
			jse_pkg::SLOT_C2_D0:   slot_byte = jse_pkg::hex_digit(cur_q.code2[3:0]);
			jse_pkg::SLOT_CLOSE:   slot_byte = jse_pkg::CH_QUOTE;
			default:               slot_byte = jse_pkg::CH_QUOTE;
		endcase
	end

	assign load_ok = !out_v_q || pop;
	assign adv = load_ok && (rem_q != 16'd0);
	assign rem_after = adv ? (rem_q & (rem_q - 16'd1)) : rem_q;
	assign head_pop = (rem_after == 16'd0) && !head_empty;

	always_ff @(posedge clk) begin
		if (head_pop) begin
			cur_q <= head;
		end
		if (adv) begin
			out_byte_q <= slot_byte;
			out_last_q <= (slot == jse_pkg::SLOT_CLOSE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= 16'd0;
			out_v_q <= 1'b0;
		end else begin
			rem_q <= head_pop ? head.mask : rem_after;
			if (load_ok) begin
				out_v_q <= adv;
			end
		end
	end

	assign out_byte = out_byte_q;
	assign out_last = out_last_q;
	assign empty = !out_v_q;

endmodule

FILE: rtl/json_string_escaper_utf8.sv
// Top level of the JSON string escaper with UTF-8 to \u escape conversion.
//
// Source bytes enter through a queue-style port and leave as the bytes of a
// quoted JSON string. A new byte is accepted every cycle while the internal
// four-entry command queue has room. Each accepted byte becomes zero to
// thirteen output bytes; the output sequencer emits one byte per cycle while
// the sink keeps popping, and a byte that yields nothing is not queued. The
// first output byte of a transaction passes through the command queue and
// the output register before it appears on the result ports. Bursts of
// escapes are absorbed by the queue and then throttle the input through full.
module json_string_escaper_utf8 (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] data_byte,
	input  logic       is_first,
	input  logic       is_last,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       out_last
);

	jse_pkg::cmd_t cmd;
	jse_pkg::cmd_t head;
	logic          cmd_push;
	logic          head_pop;
	logic          head_empty;
	logic          accept;

	assign accept = push && !full;

	jse_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (data_byte),
		.is_first  (is_first),
		.is_last   (is_last),
		.cmd_push  (cmd_push),
		.cmd       (cmd)
	);

	jse_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd),
		.full   (full),
		.pop    (head_pop),
		.rdata  (head),
		.empty  (head_empty)
	);

	jse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_empty (head_empty),
		.head_pop   (head_pop),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

FILE: dv/json_string_escaper_utf8_tb.sv
// Testbench that drives source bytes into the JSON string escaper and checks every output byte.
module json_string_escaper_utf8_tb;

	localparam int IDLE_PERCENT = 19;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 8;
	localparam int SINK_HOLD_CYCLES = 60;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_BSL = 8'h5c;
	localparam logic [7:0] CH_SLASH = 8'h2f;
	localparam logic [7:0] CH_LOWER_U = 8'h75;

	typedef struct packed {
		logic [7:0] ch;
		logic       close;
	} json_char_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] data_byte;
	logic       is_first;
	logic       is_last;
	logic       empty;
	logic       pop;
	logic [7:0] out_byte;
	logic       out_last;

	json_char_t  expected_chars[$];
	logic [2:0]  utf8_pending;
	logic [30:0] utf8_value;

	int  error_count = 0;
	int  items_sent = 0;
	int  strings_sent = 0;
	int  chars_checked = 0;
	int  sink_hold = 0;
	bit  sender_idling = 1'b1;
	bit  sink_idling = 1'b1;

	json_string_escaper_utf8 dut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.data_byte(data_byte),
		.is_first(is_first),
		.is_last(is_last),
		.empty(empty),
		.pop(pop),
		.out_byte(out_byte),
		.out_last(out_last)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic void queue_char(input logic [7:0] ch, input logic close);
		json_char_t c;
		c.ch = ch;
		c.close = close;
		expected_chars.insert(expected_chars.size(), c);
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nibble);
		return (nibble < 4'd10) ? 8'h30 + 8'(nibble) : 8'h57 + 8'(nibble);
	endfunction

	function automatic void queue_code_escape(input logic [30:0] value);
		if (value != '0 && value[30:16] == '0) begin
			queue_char(CH_BSL, 1'b0);
			queue_char(CH_LOWER_U, 1'b0);
			queue_char(hex_char(value[15:12]), 1'b0);
			queue_char(hex_char(value[11:8]), 1'b0);
			queue_char(hex_char(value[7:4]), 1'b0);
			queue_char(hex_char(value[3:0]), 1'b0);
		end
	endfunction

	function automatic logic [7:0] escaped_letter(input logic [7:0] b);
		case (b)
			8'h08: return "b";
			8'h09: return "t";
			8'h0a: return "n";
			8'h0c: return "f";
			8'h0d: return "r";
			CH_QUOTE, CH_SLASH, CH_BSL: return b;
			default: return 8'h00;
		endcase
	endfunction

	function automatic void start_utf8(input logic [30:0] bits, input logic [2:0] count);
		utf8_value = bits;
		utf8_pending = count;
	endfunction

	// Works out the output bytes that one accepted source byte produces.
	function automatic void predict_escaped_bytes(input logic [7:0] b, input logic first,
			input logic last);
		logic       consumed;
		logic [7:0] letter;
		consumed = 1'b0;
		if (first) begin
			queue_char(CH_QUOTE, 1'b0);
			start_utf8('0, '0);
		end
		if (utf8_pending != '0) begin
			if (b[7:6] == 2'b10) begin
				utf8_value = {utf8_value[24:0], b[5:0]};
				utf8_pending = utf8_pending - 3'd1;
				if (utf8_pending == '0) begin
					queue_code_escape(utf8_value);
					utf8_value = '0;
				end
				consumed = 1'b1;
			end else begin
				queue_code_escape(utf8_value);
				start_utf8('0, '0);
			end
		end
		if (!consumed) begin
			if (b < 8'h80) begin
				if (b != 8'h00) begin
					letter = escaped_letter(b);
					if (letter != 8'h00) begin
						queue_char(CH_BSL, 1'b0);
						queue_char(letter, 1'b0);
					end else begin
						queue_char(b, 1'b0);
					end
				end
			end else if (b < 8'hc0) begin
				queue_char(b, 1'b0);
			end else if (b < 8'he0) begin
				start_utf8(31'(b[4:0]), 3'd1);
			end else if (b < 8'hf0) begin
				start_utf8(31'(b[3:0]), 3'd2);
			end else if (b < 8'hf8) begin
				start_utf8(31'(b[2:0]), 3'd3);
			end else if (b < 8'hfc) begin
				start_utf8(31'(b[1:0]), 3'd4);
			end else if (b < 8'hfe) begin
				start_utf8(31'(b[0]), 3'd5);
			end else begin
				queue_char(b, 1'b0);
			end
		end
		if (last) begin
			if (utf8_pending != '0) begin
				queue_code_escape(utf8_value);
			end
			start_utf8('0, '0);
			queue_char(CH_QUOTE, 1'b1);
		end
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("MISMATCH at %0t: %s got 0x%02h expected 0x%02h", $time, what, got, want);
		error_count++;
	endtask

	task automatic check_output(input logic [7:0] got_byte, input logic got_last);
		json_char_t want;
		chars_checked++;
		if (expected_chars.size() == 0) begin
			report_mismatch("unexpected transaction, out_byte", got_byte, 0);
		end else begin
			want = expected_chars.pop_front();
			if (got_byte !== want.ch) begin
				report_mismatch("out_byte", got_byte, want.ch);
			end
			if (got_last !== want.close) begin
				report_mismatch("out_last", got_last, want.close);
			end
		end
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_byte(input logic [7:0] b, input logic first, input logic last);
		while (sender_idling && $urandom_range(0, 99) < IDLE_PERCENT) begin
			push = 1'b0;
			@(negedge clk);
		end
		push = 1'b1;
		data_byte = b;
		is_first = first;
		is_last = last;
		@(posedge clk);
		while (full) begin
			@(posedge clk);
		end
		predict_escaped_bytes(b, first, last);
		items_sent++;
		@(negedge clk);
		push = 1'b0;
	endtask

	task automatic send_string(input int parts, input bit flag_faults);
		logic [7:0] text[$];
		logic [7:0] lead;
		int         kind;
		int         seq_len;
		int         keep;
		int         zero_conts;
		for (int p = 0; p < parts; p++) begin
			kind = $urandom_range(0, 9);
			case (kind)
				0, 1, 2: text.insert(text.size(), 8'($urandom_range(8'h20, 8'h7e)));
				3: begin
					case ($urandom_range(0, 8))
						0: text.insert(text.size(), 8'h08);
						1: text.insert(text.size(), 8'h09);
						2: text.insert(text.size(), 8'h0a);
						3: text.insert(text.size(), 8'h0c);
						4: text.insert(text.size(), 8'h0d);
						5: text.insert(text.size(), CH_QUOTE);
						6: text.insert(text.size(), CH_SLASH);
						7: text.insert(text.size(), CH_BSL);
						default: text.insert(text.size(), 8'h00);
					endcase
				end
				4, 5, 6, 7: begin
					seq_len = $urandom_range(2, 6);
					lead = 8'($urandom());
					case (seq_len)
						2: lead = {3'b110, lead[4:0]};
						3: lead = {4'b1110, lead[3:0]};
						4: lead = {5'b11110, lead[2:0]};
						5: lead = {6'b111110, lead[1:0]};
						default: lead = {7'b1111110, lead[0]};
					endcase
					zero_conts = 0;
					if (seq_len >= 4 && $urandom_range(0, 1) == 1) begin
						lead = lead & ~(8'hff >> (seq_len + 1));
						zero_conts = seq_len - 3;
					end
					keep = (kind == 7) ? $urandom_range(0, seq_len - 2) : seq_len - 1;
					text.insert(text.size(), lead);
					for (int c = 0; c < keep; c++) begin
						text.insert(text.size(),
							c < zero_conts ? 8'h80 : {2'b10, 6'($urandom())});
					end
				end
				8: text.insert(text.size(), 8'($urandom_range(0, 255)));
				default: begin
					if ($urandom_range(0, 3) == 0) begin
						text.insert(text.size(), {7'b1111111, 1'($urandom())});
					end else begin
						text.insert(text.size(), {2'b10, 6'($urandom())});
					end
				end
			endcase
		end
		foreach (text[i]) begin
			send_byte(text[i],
				i == 0 && !(flag_faults && $urandom_range(0, 19) == 0),
				i == text.size() - 1 && !(flag_faults && $urandom_range(0, 19) == 0));
		end
		strings_sent++;
	endtask

	task automatic wait_drained();
		while (expected_chars.size() != 0) begin
			@(negedge clk);
		end
		repeat (TAIL_CYCLES) @(negedge clk);
	endtask

	task automatic test_directed();
		send_byte(CH_QUOTE, 1'b1, 1'b0);
		send_byte(CH_SLASH, 1'b0, 1'b0);
		send_byte(CH_BSL, 1'b0, 1'b0);
		send_byte(8'h08, 1'b0, 1'b0);
		send_byte(8'h09, 1'b0, 1'b0);
		send_byte(8'h0a, 1'b0, 1'b0);
		send_byte(8'h0c, 1'b0, 1'b0);
		send_byte(8'h0d, 1'b0, 1'b0);
		send_byte(8'h00, 1'b0, 1'b0);
		send_byte(8'h80, 1'b0, 1'b0);
		send_byte(8'hfe, 1'b0, 1'b0);
		send_byte(8'hff, 1'b0, 1'b0);
		send_byte(8'hc3, 1'b0, 1'b0);
		send_byte(8'ha9, 1'b0, 1'b0);
		// A lead byte followed by plain ASCII flushes the partial code point.
		send_byte(8'he2, 1'b0, 1'b0);
		send_byte(8'h41, 1'b0, 1'b0);
		// A four-byte sequence above the basic plane is dropped.
		send_byte(8'hf0, 1'b0, 1'b0);
		send_byte(8'h9f, 1'b0, 1'b0);
		send_byte(8'h98, 1'b0, 1'b0);
		send_byte(8'h80, 1'b0, 1'b0);
		// A six-byte lead cut short with a zero value produces nothing.
		send_byte(8'hfc, 1'b0, 1'b0);
		send_byte(8'h80, 1'b0, 1'b0);
		send_byte(8'h5a, 1'b0, 1'b0);
		// A new string while a sequence is pending discards it silently.
		send_byte(8'hd0, 1'b0, 1'b0);
		send_byte(8'h41, 1'b1, 1'b1);
		// The last byte arrives in the middle of a sequence.
		send_byte(8'hef, 1'b1, 1'b0);
		send_byte(8'hbf, 1'b0, 1'b1);
		strings_sent += 3;
	endtask

	task automatic test_random_strings();
		int target;
		target = items_sent + 165;
		while (items_sent < target) begin
			send_string($urandom_range(1, 8), 1'b1);
		end
	endtask

	task automatic test_no_idle_burst();
		int target;
		target = items_sent + 50;
		sender_idling = 1'b0;
		sink_idling = 1'b0;
		while (items_sent < target) begin
			send_string($urandom_range(2, 10), 1'b0);
		end
		sender_idling = 1'b1;
		sink_idling = 1'b1;
	endtask

	task automatic test_output_stall();
		sink_hold = SINK_HOLD_CYCLES;
		sender_idling = 1'b0;
		for (int i = 0; i < 24; i++) begin
			send_byte((i % 3 == 0) ? CH_QUOTE : ((i % 3 == 1) ? 8'hc4 : 8'h81),
				i == 0, i == 23);
		end
		strings_sent++;
		sender_idling = 1'b1;
		wait_drained();
	endtask

	initial begin : sink
		pop = 1'b0;
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				check_output(out_byte, out_last);
			end
			@(negedge clk);
			if (sink_hold > 0) begin
				pop = 1'b0;
				sink_hold--;
			end else begin
				pop = !(sink_idling && $urandom_range(0, 99) < IDLE_PERCENT);
			end
		end
	end

	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		while (quiet_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
			end
		end
		$display("Timeout: no transaction for %0d cycles", STALL_LIMIT);
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		push = 1'b0;
		data_byte = 8'h00;
		is_first = 1'b0;
		is_last = 1'b0;
		utf8_pending = '0;
		utf8_value = '0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random_strings();
		test_output_stall();
		test_no_idle_burst();
		wait_drained();
		$display("Sent %0d source bytes in %0d strings and checked %0d output bytes.",
			items_sent, strings_sent, chars_checked);
		$display("Covered escapes, UTF-8 sequences of two to six bytes, broken sequences, "
			, "missing flags and a long output stall.");
		if (error_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
